FILE: hdl/arqrx_pkg.sv
// Package: shared constants, types and state codes of the ARQ receiver.
`timescale 1ns / 1ps
package arqrx_pkg;

    localparam int SSN_BITS = 16;
    localparam int WIN_MAX  = 64;
    localparam int SLOT_W   = $clog2(WIN_MAX);
    localparam int CNT_W    = $clog2(WIN_MAX + 1);
    localparam int CFG_W    = 7;

    typedef logic [SSN_BITS-1:0] ssn_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [WIN_MAX-1:0]  bitmap_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_WALK,
        ST_FINISH,
        ST_CLEAR
    } state_t;

    // Force a written window size into 1..WIN_MAX.
    function automatic cnt_t clamp_window(input logic [CFG_W-1:0] value);
        cnt_t result;
        if (value == '0) begin
            result = cnt_t'(1);
        end
        else if (CFG_W'(value) > CFG_W'(WIN_MAX)) begin
            result = cnt_t'(WIN_MAX);
        end
        else begin
            result = cnt_t'(value);
        end
        return result;
    endfunction

endpackage

FILE: hdl/arqrx_seg_if.sv
// Interface: channel of received segments.
`timescale 1ns / 1ps
interface arqrx_seg_if;
    import arqrx_pkg::*;

    logic       valid;
    logic       ready;
    ssn_t       segment_ssn;
    logic       segment_good;
    logic       last_in_batch;

    modport source (output valid, output segment_ssn, output segment_good,
                    output last_in_batch, input ready);
    modport sink   (input valid, input segment_ssn, input segment_good,
                    input last_in_batch, output ready);
endinterface

FILE: hdl/arqrx_ack_if.sv
// Interface: channel of bitmap acknowledgements.
`timescale 1ns / 1ps
interface arqrx_ack_if;
    import arqrx_pkg::*;

    logic       valid;
    logic       ready;
    ssn_t       ack_win_start;
    bitmap_t    ack_bitmap;
    cnt_t       ack_length;
    cnt_t       contiguous_count;

    modport source (output valid, output ack_win_start, output ack_bitmap,
                    output ack_length, output contiguous_count, input ready);
    modport sink   (input valid, input ack_win_start, input ack_bitmap,
                    input ack_length, input contiguous_count, output ready);
endinterface

FILE: hdl/arq_rx_bitmap_ack_top.sv
// Top level: selective-repeat ARQ receiver building bitmap acknowledgements.
`timescale 1ns / 1ps
// A segment that does not end a batch is taken in ST_IDLE: if it lies in the
// window, its slot's good bit is written to the slot RAM and its received flag
// is set. A segment that ends a batch is followed by a window walk that reads
// the slot RAM one slot a cycle through its single read port: ST_PRIME primes
// the read, ST_WALK steps until a slot not received or a full window, ST_FINISH
// hands the acknowledgement to the output register (waiting if the previous one
// has not been taken), then ST_CLEAR clears the received flags of each slot the
// window advances. No segment is taken during the walk and the clearing. A
// pending acknowledgement does not stop new segments.
// Writing window_size empties all slots and puts the window start on slot 0;
// the sequence number of the window start is kept.
module arq_rx_bitmap_ack_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [arqrx_pkg::CFG_W-1:0] cfg_wdata,
    arqrx_seg_if.sink                 seg,
    arqrx_ack_if.source               ack
);
    import arqrx_pkg::*;

    state_t   state_reg, state_next;
    cnt_t     win_reg, win_next;
    slot_t    start_slot_reg, start_slot_next;
    ssn_t     start_ssn_reg, start_ssn_next;
    ssn_t     first_ssn_reg, first_ssn_next;
    logic     in_batch_reg, in_batch_next;
    bitmap_t  rcvd_reg, rcvd_next;
    slot_t    ptr_reg, ptr_next;
    cnt_t     cnt_reg, cnt_next;
    cnt_t     len_reg, len_next;
    logic     bm_phase_reg, bm_phase_next;
    bitmap_t  bitmap_reg, bitmap_next;
    cnt_t     clr_left_reg, clr_left_next;

    logic     ack_valid_reg, ack_valid_next;
    ssn_t     ack_start_reg, ack_start_next;
    bitmap_t  ack_bitmap_reg, ack_bitmap_next;
    cnt_t     ack_len_reg, ack_len_next;
    cnt_t     ack_cnt_reg, ack_cnt_next;

    logic     ram_we;
    slot_t    ram_waddr;
    logic     ram_wdata;
    slot_t    ram_raddr;
    logic     ram_rdata;

    logic     seg_fire;
    ssn_t     seg_off;
    logic     seg_in_win;
    logic [CNT_W:0] mark_sum;
    slot_t    mark_slot;

    slot_t    ptr_adv;
    logic     walk_full;
    logic     slot_vld;
    logic     slot_done;
    logic     walk_stop;

    ssn_t     limit;
    cnt_t     adv;
    logic [CNT_W:0] start_sum;
    logic     out_free;

    arqrx_ram #(
        .WIDTH (1),
        .DEPTH (WIN_MAX)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next slot after the walk pointer, wrapping at the window size.
    assign ptr_adv = ((CNT_W'(ptr_reg) + cnt_t'(1)) == win_reg) ? '0 : ptr_reg + slot_t'(1);

    assign seg_fire   = seg.valid && seg.ready;
    assign seg_off    = seg.segment_ssn - start_ssn_reg;
    assign seg_in_win = seg_off < ssn_t'(win_reg);
    assign mark_sum   = (CNT_W+1)'(start_slot_reg) + (CNT_W+1)'(seg_off[CNT_W-1:0]);
    assign mark_slot  = (mark_sum >= (CNT_W+1)'(win_reg))
                        ? SLOT_W'(mark_sum - (CNT_W+1)'(win_reg)) : SLOT_W'(mark_sum);

    assign walk_full = (cnt_reg + len_reg) == win_reg;
    assign slot_vld  = rcvd_reg[ptr_reg];
    assign slot_done = slot_vld && ram_rdata;
    assign walk_stop = walk_full || !slot_vld;

    assign limit     = (first_ssn_reg + ssn_t'(win_reg)) - start_ssn_reg;
    assign adv       = (ssn_t'(cnt_reg) < limit) ? cnt_reg : CNT_W'(limit);
    assign start_sum = (CNT_W+1)'(start_slot_reg) + (CNT_W+1)'(adv);
    assign out_free  = !ack_valid_reg || ack.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (seg_fire && seg.last_in_batch)
                begin
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (walk_stop)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = (adv != '0) ? ST_CLEAR : ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                if (clr_left_reg == cnt_t'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        win_next        = win_reg;
        start_slot_next = start_slot_reg;
        start_ssn_next  = start_ssn_reg;
        first_ssn_next  = first_ssn_reg;
        in_batch_next   = in_batch_reg;
        rcvd_next       = rcvd_reg;
        ptr_next        = ptr_reg;
        cnt_next        = cnt_reg;
        len_next        = len_reg;
        bm_phase_next   = bm_phase_reg;
        bitmap_next     = bitmap_reg;
        clr_left_next   = clr_left_reg;
        ack_valid_next  = ack_valid_reg && !ack.ready;
        ack_start_next  = ack_start_reg;
        ack_bitmap_next = ack_bitmap_reg;
        ack_len_next    = ack_len_reg;
        ack_cnt_next    = ack_cnt_reg;
        ram_we          = 1'b0;
        ram_waddr       = mark_slot;
        ram_wdata       = seg.segment_good;
        ram_raddr       = ptr_adv;
        seg.ready       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                seg.ready = 1'b1;
                if (seg_fire)
                begin
                    if (!in_batch_reg)
                    begin
                        first_ssn_next = seg.segment_ssn;
                    end
                    in_batch_next = !seg.last_in_batch;
                    if (seg_in_win)
                    begin
                        ram_we               = 1'b1;
                        rcvd_next[mark_slot] = 1'b1;
                    end
                end
            end
            ST_PRIME:
            begin
                ram_raddr     = start_slot_reg;
                ptr_next      = start_slot_reg;
                cnt_next      = '0;
                len_next      = '0;
                bm_phase_next = 1'b0;
                bitmap_next   = '0;
            end
            ST_WALK:
            begin
                if (!walk_stop)
                begin
                    ptr_next = ptr_adv;
                    if (!bm_phase_reg && slot_done)
                    begin
                        cnt_next = cnt_reg + cnt_t'(1);
                    end
                    else
                    begin
                        // first retransmit slot opens the bitmap
                        bm_phase_next = 1'b1;
                        bitmap_next[len_reg[SLOT_W-1:0]] = slot_done;
                        len_next = len_reg + cnt_t'(1);
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    ack_valid_next  = 1'b1;
                    ack_start_next  = start_ssn_reg + ssn_t'(cnt_reg);
                    ack_bitmap_next = bitmap_reg;
                    ack_len_next    = len_reg;
                    ack_cnt_next    = cnt_reg;
                    start_ssn_next  = start_ssn_reg + ssn_t'(adv);
                    start_slot_next = (start_sum >= (CNT_W+1)'(win_reg))
                                      ? SLOT_W'(start_sum - (CNT_W+1)'(win_reg))
                                      : SLOT_W'(start_sum);
                    ptr_next        = start_slot_reg;
                    clr_left_next   = adv;
                end
            end
            ST_CLEAR:
            begin
                rcvd_next[ptr_reg] = 1'b0;
                ptr_next           = ptr_adv;
                clr_left_next      = clr_left_reg - cnt_t'(1);
            end
            default:
            begin
                seg.ready = 1'b0;
            end
        endcase

        // new window size empties every slot
        if (cfg_we)
        begin
            win_next        = clamp_window(cfg_wdata);
            rcvd_next       = '0;
            start_slot_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            win_reg        <= cnt_t'(WIN_MAX);
            start_slot_reg <= '0;
            start_ssn_reg  <= '0;
            in_batch_reg   <= 1'b0;
            rcvd_reg       <= '0;
            ack_valid_reg  <= 1'b0;
            clr_left_reg   <= '0;
            bm_phase_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            win_reg        <= win_next;
            start_slot_reg <= start_slot_next;
            start_ssn_reg  <= start_ssn_next;
            in_batch_reg   <= in_batch_next;
            rcvd_reg       <= rcvd_next;
            ack_valid_reg  <= ack_valid_next;
            clr_left_reg   <= clr_left_next;
            bm_phase_reg   <= bm_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_ssn_reg  <= first_ssn_next;
        ptr_reg        <= ptr_next;
        cnt_reg        <= cnt_next;
        len_reg        <= len_next;
        bitmap_reg     <= bitmap_next;
        ack_start_reg  <= ack_start_next;
        ack_bitmap_reg <= ack_bitmap_next;
        ack_len_reg    <= ack_len_next;
        ack_cnt_reg    <= ack_cnt_next;
    end

    assign ack.valid            = ack_valid_reg;
    assign ack.ack_win_start    = ack_start_reg;
    assign ack.ack_bitmap       = ack_bitmap_reg;
    assign ack.ack_length       = ack_len_reg;
    assign ack.contiguous_count = ack_cnt_reg;
endmodule

FILE: hdl/arqrx_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module arqrx_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
